[design/minmax_normalize_inverted_defines.svh]
// Assertion macros used by the normalizer top level.
// Both macros sample on clk and are switched off while rst_n is low.
`ifndef MINMAX_NORMALIZE_INVERTED_DEFINES_SVH
`define MINMAX_NORMALIZE_INVERTED_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MMNI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("minmax_normalize_inverted: assertion failed");

// Consequent checked in the cycle after the antecedent.
`define MMNI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("minmax_normalize_inverted: assertion failed");

`endif

[design/mmni_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmni_pkg
// Types, widths, constants and decode helpers for the min-max normalizer.
// ----------------------------------------------------------------------------
package mmni_pkg;

    localparam int VALUE_WIDTH  = 32;
    localparam int SAMPLE_WIDTH = 33;
    localparam int STORE_WIDTH  = 32;
    localparam int PLOT_WIDTH   = 32;
    localparam int QUOT_WIDTH   = 32;
    localparam int CNT_WIDTH    = $clog2(QUOT_WIDTH + 1);
    localparam int PADDR_WIDTH  = 3;
    localparam int PDATA_WIDTH  = 32;

    localparam logic [PLOT_WIDTH-1:0] MID_CODE = {1'b1, {(PLOT_WIDTH-1){1'b0}}};

    // Register index taken from paddr[2].
    localparam logic REG_SIGNED_VALUES = 1'b0;

    typedef logic signed [SAMPLE_WIDTH-1:0] value_t;

    typedef struct packed {
        logic                   load;
        logic [QUOT_WIDTH-1:0]  num_hi;
        logic [QUOT_WIDTH-1:0]  num_lo;
        logic [QUOT_WIDTH-1:0]  divisor;
    } div_cmd_t;

    typedef struct packed {
        logic                   busy;
        logic [QUOT_WIDTH-1:0]  quotient;
    } div_stat_t;

    typedef struct packed {
        logic   update;
        logic   restart;
        value_t value;
    } range_upd_t;

    // Low VALUE_WIDTH bits of a sample, zero- or sign-extended per mode.
    function automatic value_t decode_sample(logic [SAMPLE_WIDTH-1:0] raw, logic sgn);
        value_t r;
        r = '0;
        r[VALUE_WIDTH-1:0] = raw[VALUE_WIDTH-1:0];
        for (int i = VALUE_WIDTH; i < SAMPLE_WIDTH; i++)
        begin
            r[i] = sgn & raw[VALUE_WIDTH-1];
        end
        return r;
    endfunction

    // A stored pattern, read as unsigned or two's complement per mode.
    function automatic value_t decode_store(logic [STORE_WIDTH-1:0] s, logic sgn);
        return value_t'({sgn & s[STORE_WIDTH-1], s});
    endfunction

endpackage

[design/mmni_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmni_in_if
// Input stream channel: one column value per beat.
// ----------------------------------------------------------------------------
interface mmni_in_if
    import mmni_pkg::*;
();
    logic                           valid;
    logic                           ready;
    logic                           kind;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           start_req;
    logic                           last_in;

    modport source (output valid, output kind, output sample, output start_req,
                    output last_in, input ready);
    modport sink   (input valid, input kind, input sample, input start_req,
                    input last_in, output ready);
endinterface

[design/mmni_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmni_out_if
// Output stream channel: one plot coordinate per beat.
// ----------------------------------------------------------------------------
interface mmni_out_if
    import mmni_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [PLOT_WIDTH-1:0] plotted;
    logic                  last_out;

    modport source (output valid, output plotted, output last_out, input ready);
    modport sink   (input valid, input plotted, input last_out, output ready);
endinterface

[design/mmni_range.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmni_range
// Running minimum and maximum of the column, gathered in pass one.
// ----------------------------------------------------------------------------
module mmni_range
    import mmni_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       signed_mode,
    input  range_upd_t upd,
    output value_t     lo,
    output value_t     hi
);

    logic [STORE_WIDTH-1:0] range_low_reg;
    logic [STORE_WIDTH-1:0] range_high_reg;
    logic                   below;
    logic                   above;

    assign lo = decode_store(range_low_reg, signed_mode);
    assign hi = decode_store(range_high_reg, signed_mode);

    assign below = upd.value < lo;
    assign above = upd.value > hi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg  <= '0;
            range_high_reg <= '0;
        end
        else if (upd.update)
        begin
            if (upd.restart || below)
            begin
                range_low_reg <= upd.value[STORE_WIDTH-1:0];
            end
            if (upd.restart || above)
            begin
                range_high_reg <= upd.value[STORE_WIDTH-1:0];
            end
        end
    end

endmodule

[design/mmni_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmni_div
// Restoring divider, one quotient bit per cycle, 64-by-32 bits.
// ----------------------------------------------------------------------------
module mmni_div
    import mmni_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  div_cmd_t  cmd,
    output div_stat_t stat
);

    logic [CNT_WIDTH-1:0]  cnt_reg;
    logic [QUOT_WIDTH-1:0] rem_reg;
    logic [QUOT_WIDTH-1:0] quo_reg;
    logic [QUOT_WIDTH-1:0] div_reg;

    logic [QUOT_WIDTH:0]   partial;
    logic [QUOT_WIDTH:0]   trial;
    logic                  fits;
    logic [QUOT_WIDTH-1:0] rem_next;

    // The quotient register first holds the low dividend half and shifts
    // it out while the quotient bits shift in.
    assign partial  = {rem_reg, quo_reg[QUOT_WIDTH-1]};
    assign trial    = partial - {1'b0, div_reg};
    assign fits     = partial >= {1'b0, div_reg};
    assign rem_next = fits ? trial[QUOT_WIDTH-1:0] : partial[QUOT_WIDTH-1:0];

    assign stat.busy     = cnt_reg != '0;
    assign stat.quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg <= CNT_WIDTH'(QUOT_WIDTH);
        end
        else if (stat.busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= cmd.num_hi;
            quo_reg <= cmd.num_lo;
            div_reg <= cmd.divisor;
        end
        else if (stat.busy)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QUOT_WIDTH-2:0], fits};
        end
    end

endmodule

[design/minmax_normalize_inverted.sv]
// Pass-one beats are accepted while idle, update the range and produce no result.
// A pass-two beat goes through ST_PREP, ST_LOAD, the 32 steps of the divider and
// ST_DONE, the input being blocked meanwhile; ST_DONE waits while the output is full.
// An empty or inverted range skips the divider, going from ST_PREP to ST_DONE.
// rst_n clears the range to zero, the mode to unsigned and the output stage.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minmax_normalize_inverted
// Two-pass min-max normalizer producing inverted 32-bit plot coordinates.
// ----------------------------------------------------------------------------
`include "minmax_normalize_inverted_defines.svh"

module minmax_normalize_inverted
    import mmni_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_WIDTH-1:0] paddr,
    input  logic [PDATA_WIDTH-1:0] pwdata,
    output logic [PDATA_WIDTH-1:0] prdata,
    output logic                   pready,
    mmni_in_if.sink                items,
    mmni_out_if.source             results
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_LOAD,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic                   signed_reg;
    value_t                 val_reg;
    logic                   last_reg;
    logic                   flat_reg;
    logic [QUOT_WIDTH-1:0]  dist_reg;
    logic [QUOT_WIDTH-1:0]  diff_reg;
    logic                   out_valid_reg;
    logic [PLOT_WIDTH-1:0]  plotted_reg;
    logic                   last_out_reg;

    value_t                 lo;
    value_t                 hi;
    value_t                 clamped;
    value_t                 dist_full;
    value_t                 diff_full;
    logic [2*QUOT_WIDTH-1:0] num;
    logic                   in_beat;
    logic                   out_beat;
    logic                   out_free;
    range_upd_t             range_upd;
    div_cmd_t               div_cmd;
    div_stat_t              div_stat;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SIGNED_VALUES) ?
                    {{(PDATA_WIDTH-1){1'b0}}, signed_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_SIGNED_VALUES)
        begin
            signed_reg <= pwdata[0];
        end
    end

    assign items.ready     = state_reg == ST_IDLE;
    assign in_beat         = items.valid && items.ready;
    assign results.valid   = out_valid_reg;
    assign results.plotted = plotted_reg;
    assign results.last_out = last_out_reg;
    assign out_beat        = results.valid && results.ready;
    assign out_free        = !out_valid_reg || results.ready;

    assign range_upd.update  = in_beat && !items.kind;
    assign range_upd.restart = items.start_req;
    assign range_upd.value   = decode_sample(items.sample, signed_reg);

    mmni_range u_range (
        .clk         (clk),
        .rst_n       (rst_n),
        .signed_mode (signed_reg),
        .upd         (range_upd),
        .lo          (lo),
        .hi          (hi)
    );

    // Clamp into the gathered range before measuring the distance.
    always_comb
    begin
        if (val_reg < lo)
        begin
            clamped = lo;
        end
        else if (val_reg > hi)
        begin
            clamped = hi;
        end
        else
        begin
            clamped = val_reg;
        end
    end

    assign dist_full = clamped - lo;
    assign diff_full = hi - lo;

    // Scaling by 2^32 - 1 is a shift and a subtract.
    assign num = {dist_reg, {QUOT_WIDTH{1'b0}}} - {{QUOT_WIDTH{1'b0}}, dist_reg};

    assign div_cmd.load    = state_reg == ST_LOAD;
    assign div_cmd.num_hi  = num[2*QUOT_WIDTH-1:QUOT_WIDTH];
    assign div_cmd.num_lo  = num[QUOT_WIDTH-1:0];
    assign div_cmd.divisor = diff_reg;

    mmni_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .stat  (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            val_reg       <= '0;
            last_reg      <= 1'b0;
            flat_reg      <= 1'b0;
            dist_reg      <= '0;
            diff_reg      <= '0;
            plotted_reg   <= '0;
            last_out_reg  <= 1'b0;
        end
        else
        begin
            // In ST_DONE the output stage is always free on a taken beat and
            // is reloaded there instead.
            if (out_beat && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_beat && items.kind)
                    begin
                        val_reg   <= decode_sample(items.sample, signed_reg);
                        last_reg  <= items.last_in;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    flat_reg <= hi <= lo;
                    dist_reg <= dist_full[QUOT_WIDTH-1:0];
                    diff_reg <= diff_full[QUOT_WIDTH-1:0];
                    state_reg <= (hi <= lo) ? ST_DONE : ST_LOAD;
                end
                ST_LOAD:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (!div_stat.busy)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        plotted_reg   <= flat_reg ? MID_CODE : ~div_stat.quotient;
                        last_out_reg  <= last_reg;
                        state_reg     <= ST_IDLE;
                    end
                    else if (out_beat)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A restart beat leaves a one-point range.
    `MMNI_ASSERT_NEXT(a_restart_point, in_beat && !items.kind && items.start_req, lo == hi)
    // A normalize beat blocks the input on the next cycle.
    `MMNI_ASSERT_NEXT(a_busy_after_norm, in_beat && items.kind, !items.ready)
    // An empty or inverted range always yields the midpoint code.
    `MMNI_ASSERT_NEXT(a_flat_mid, state_reg == ST_DONE && out_free && flat_reg,
                      results.valid && results.plotted == MID_CODE)
    // The divider runs only while the sequencer waits on it.
    `MMNI_ASSERT_SAME(a_div_owned, div_stat.busy, state_reg == ST_DIV)

endmodule
